// ===== sv/tlb_fifo_fully_associative_top_macros.svh =====
// assertion helpers used by the translation buffer datapath
`ifndef TLB_FIFO_FULLY_ASSOCIATIVE_TOP_MACROS_SVH
`define TLB_FIFO_FULLY_ASSOCIATIVE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TLBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tlbf_pkg.sv =====
`default_nettype none

package tlbf_pkg;

    localparam int ENTRIES          = 16;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int FRAME_BITS       = 16;
    localparam int OWNER_BITS       = 16;

    localparam int PAGE_BITS   = 20;
    localparam int VADDR_BITS  = 32;
    localparam int OWNER_W     = 16;
    localparam int FRAME_W     = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OWNER_KEEP  = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
    localparam int FRAME_KEEP  = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;

    typedef enum logic [1:0] {
        MODE_LOOKUP     = 2'd0,
        MODE_INSERT     = 2'd1,
        MODE_INVALIDATE = 2'd2,
        MODE_FLUSH      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic                  is_write;
        logic [OWNER_W-1:0]    owner_id;
        logic [VADDR_BITS-1:0] virt_address;
        logic [PAGE_BITS-1:0]  page_number;
        logic [FRAME_W-1:0]    frame_number;
        logic                  frame_dirty_in;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] found_frame;
        logic               mark_dirty;
        logic               mark_ref;
        logic [FRAME_W-1:0] marked_frame;
    } out_word_t;

    typedef struct packed {
        logic load_in;
        logic search;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tlb_fifo_fully_associative_top.sv =====
// channel | ports                     | word type             | direction
// --------+---------------------------+-----------------------+----------
// request | s_valid, s_ready, s_word  | tlbf_pkg::in_word_t   | in
// result  | m_valid, m_ready, m_word  | tlbf_pkg::out_word_t  | out
//
// each request passes three steps: accept, tag compare over all entries, apply
// the compare result is registered before the entry update, which sets the rate
// one result word per request, held in an output register until taken
// aresetn is synchronous, active low: clears valid marks, victim pointer, hit flag, result valid and state
// s_ready is high only in idle; a waiting result word holds the next request
// in its apply step, so at most one request sits behind a stalled result

`default_nettype none

module tlb_fifo_fully_associative_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tlbf_pkg::in_word_t  s_word,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tlbf_pkg::out_word_t      m_word
);

    // controller to datapath commands and status back
    tlbf_pkg::dp_cmd_t    cmd;
    tlbf_pkg::dp_status_t status;

    // sequencer: idle, compare, apply
    tlbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // entries, tag compare, victim pointer and result register
    tlbf_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .m_word  (m_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

// ===== sv/tlbf_ctrl.sv =====
`default_nettype none

module tlbf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tlbf_pkg::dp_status_t status,
    output tlbf_pkg::dp_cmd_t         cmd
);

    tlbf_pkg::state_t state_reg;
    tlbf_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlbf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            tlbf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = tlbf_pkg::ST_SEARCH;
                end
            end
            tlbf_pkg::ST_SEARCH: begin
                cmd.search = 1'b1;
                state_next = tlbf_pkg::ST_APPLY;
            end
            tlbf_pkg::ST_APPLY: begin
                // wait for room in the result register
                if (status.out_free) begin
                    cmd.apply  = 1'b1;
                    state_next = tlbf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tlbf_datapath.sv =====
`default_nettype none

`include "tlb_fifo_fully_associative_top_macros.svh"

module tlbf_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tlbf_pkg::in_word_t   s_word,
    output tlbf_pkg::out_word_t       m_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire tlbf_pkg::dp_cmd_t    cmd,
    output tlbf_pkg::dp_status_t      status
);

    localparam int N  = tlbf_pkg::ENTRIES;
    localparam int IW = tlbf_pkg::IDX_W;
    localparam int OK = tlbf_pkg::OWNER_KEEP;
    localparam int FK = tlbf_pkg::FRAME_KEEP;
    localparam int PB = tlbf_pkg::PAGE_BITS;

    // entry storage
    logic          valid_reg [N];
    logic [OK-1:0] owner_reg [N];
    logic [PB-1:0] page_reg  [N];
    logic [FK-1:0] frame_reg [N];
    logic          dirty_reg [N];
    logic          ref_reg   [N];
    logic [IW-1:0] victim_reg;
    logic [IW-1:0] victim_next;

    tlbf_pkg::in_word_t  in_reg;
    tlbf_pkg::out_word_t out_reg;
    tlbf_pkg::out_word_t out_next;
    logic                out_valid_reg;

    logic [N-1:0]  match_vec;
    logic          match_any_reg;
    logic [IW-1:0] match_idx_reg;
    logic [IW-1:0] match_idx;

    logic [OK-1:0] key_owner;
    logic [PB-1:0] key_page;
    logic [PB-1:0] vpage;
    tlbf_pkg::mode_t in_mode;

    assign in_mode   = tlbf_pkg::mode_t'(in_reg.mode);
    assign key_owner = in_reg.owner_id[OK-1:0];
    assign vpage     = PB'(in_reg.virt_address >> tlbf_pkg::PAGE_OFFSET_BITS);
    assign key_page  = (in_mode == tlbf_pkg::MODE_LOOKUP) ? vpage : in_reg.page_number;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_word;
        end
    end

    // parallel tag compare
    always_comb begin
        for (int i = 0; i < N; i++) begin
            match_vec[i] = valid_reg[i] && (owner_reg[i] == key_owner)
                           && (page_reg[i] == key_page);
        end
    end

    // lowest index wins
    always_comb begin
        match_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                match_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_any_reg <= 1'b0;
        end else if (cmd.search) begin
            match_any_reg <= |match_vec;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            match_idx_reg <= match_idx;
        end
    end

    assign victim_next = (victim_reg == IW'(N - 1)) ? '0 : victim_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            victim_reg <= '0;
        end else if (cmd.apply && (in_mode == tlbf_pkg::MODE_INSERT)) begin
            victim_reg <= victim_next;
        end
    end

    // valid marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (cmd.apply) begin
            unique case (in_mode)
                tlbf_pkg::MODE_INSERT: begin
                    valid_reg[victim_reg] <= 1'b1;
                end
                tlbf_pkg::MODE_INVALIDATE: begin
                    if (match_any_reg) begin
                        valid_reg[match_idx_reg] <= 1'b0;
                    end
                end
                tlbf_pkg::MODE_FLUSH: begin
                    for (int i = 0; i < N; i++) begin
                        valid_reg[i] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // entry payload, meaningful only under a valid mark
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            unique case (in_mode)
                tlbf_pkg::MODE_LOOKUP: begin
                    if (match_any_reg) begin
                        ref_reg[match_idx_reg] <= 1'b1;
                        if (in_reg.is_write) begin
                            dirty_reg[match_idx_reg] <= 1'b1;
                        end
                    end
                end
                tlbf_pkg::MODE_INSERT: begin
                    owner_reg[victim_reg] <= key_owner;
                    page_reg[victim_reg]  <= in_reg.page_number;
                    frame_reg[victim_reg] <= in_reg.frame_number[FK-1:0];
                    dirty_reg[victim_reg] <= in_reg.is_write | in_reg.frame_dirty_in;
                    ref_reg[victim_reg]   <= 1'b1;
                end
                tlbf_pkg::MODE_FLUSH: begin
                    for (int i = 0; i < N; i++) begin
                        dirty_reg[i] <= 1'b0;
                        ref_reg[i]   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result word
    always_comb begin
        out_next = '0;
        unique case (in_mode)
            tlbf_pkg::MODE_LOOKUP: begin
                if (match_any_reg) begin
                    out_next.hit          = 1'b1;
                    out_next.found_frame  = tlbf_pkg::FRAME_W'(frame_reg[match_idx_reg]);
                    out_next.mark_dirty   = in_reg.is_write;
                    out_next.mark_ref     = 1'b1;
                    out_next.marked_frame = tlbf_pkg::FRAME_W'(frame_reg[match_idx_reg]);
                end
            end
            tlbf_pkg::MODE_INSERT: begin
                out_next.mark_dirty   = in_reg.is_write;
                out_next.mark_ref     = 1'b1;
                out_next.marked_frame = tlbf_pkg::FRAME_W'(in_reg.frame_number[FK-1:0]);
            end
            tlbf_pkg::MODE_INVALIDATE: begin
                out_next.hit = match_any_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_word          = out_reg;

    `TLBF_ASSERT_NOW(a_apply_has_room, cmd.apply, (!out_valid_reg || m_ready), "apply with result register full")
    `TLBF_ASSERT_NEXT(a_hit_tracks_compare, cmd.search, (match_any_reg == $past(|match_vec)), "hit flag does not follow compare")
    `TLBF_ASSERT_NEXT(a_victim_wraps, (cmd.apply && (in_mode == tlbf_pkg::MODE_INSERT) && (victim_reg == IW'(N - 1))), (victim_reg == '0), "victim pointer failed to wrap")
    `TLBF_ASSERT_NEXT(a_flush_clears, (cmd.apply && (in_mode == tlbf_pkg::MODE_FLUSH)), (match_vec == '0), "entry still matches after flush")

endmodule

`default_nettype wire
